// ----- src/ncm_crh_pkg.sv -----
// ----------------------------------------------------------------------------
// ncm_crh_pkg
// types, codes and constants shared by the ncm control request handler
// ----------------------------------------------------------------------------
`default_nettype none

package ncm_crh_pkg;

  localparam int unsigned CfgIdxW        = 8;
  localparam logic [31:0] InMaxReset     = 32'h0001_0000;
  localparam logic [31:0] MinInSize      = 32'd2048;
  localparam logic [15:0] ParamBlockLen  = 16'd28;
  localparam logic [15:0] FmtReplyLen    = 16'd2;
  localparam logic [15:0] SizeReplyLen   = 16'd4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMM_IF_IDX = 8'd0,
    REG_IN_MAX_SIZE = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EV_ATTACH       = 3'd0,
    EV_SUSPEND      = 3'd1,
    EV_CONFIGURED   = 3'd2,
    EV_UNCONFIGURED = 3'd3,
    EV_DETACH       = 3'd4,
    EV_RESET        = 3'd5,
    EV_SETUP        = 3'd6,
    EV_SET_IF       = 3'd7
  } func_e;

  typedef enum logic [7:0] {
    RQ_GET_PARAMS = 8'h80,
    RQ_GET_FMT    = 8'h83,
    RQ_SET_FMT    = 8'h84,
    RQ_GET_INSIZE = 8'h85,
    RQ_SET_INSIZE = 8'h86
  } request_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_STALL     = 3'd1,
    ACT_BLOCK     = 3'd2,
    ACT_VALUE     = 3'd3,
    ACT_HANDSHAKE = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    LINK_NONE    = 2'd0,
    LINK_UP      = 2'd1,
    LINK_DOWN    = 2'd2,
    LINK_RESTART = 2'd3
  } link_event_e;

  typedef enum logic [1:0] {
    ST_DETACHED   = 2'd0,
    ST_ATTACHED   = 2'd1,
    ST_DEFAULT    = 2'd2,
    ST_CONFIGURED = 2'd3
  } dev_state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  bus_speed;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
    logic [31:0] host_data;
    logic [7:0]  alt_setting;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] reply_value;
    logic [4:0]  reply_length;
    logic [1:0]  link_event;
    logic [1:0]  device_state_out;
    logic        ntb32_out;
    logic [31:0] in_size_out;
  } result_t;

  typedef struct packed {
    logic [7:0]  comm_interface_index;
    logic [31:0] ntb_in_max_size;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/ncm_crh_if.sv -----
// ----------------------------------------------------------------------------
// ncm_crh interfaces
// event, result and register write channels of the request handler
// ----------------------------------------------------------------------------
`default_nettype none

interface ncm_crh_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [2:0]  bus_speed;
  logic [7:0]  request_code;
  logic [15:0] setup_value;
  logic [15:0] setup_index;
  logic [15:0] setup_length;
  logic [31:0] host_data;
  logic [7:0]  alt_setting;

  modport source (
    output valid, func, bus_speed, request_code, setup_value, setup_index,
           setup_length, host_data, alt_setting,
    input  ready
  );
  modport sink (
    input  valid, func, bus_speed, request_code, setup_value, setup_index,
           setup_length, host_data, alt_setting,
    output ready
  );
endinterface

interface ncm_crh_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] reply_value;
  logic [4:0]  reply_length;
  logic [1:0]  link_event;
  logic [1:0]  device_state_out;
  logic        ntb32_out;
  logic [31:0] in_size_out;

  modport source (
    output valid, action, reply_value, reply_length, link_event,
           device_state_out, ntb32_out, in_size_out,
    input  ready
  );
  modport sink (
    input  valid, action, reply_value, reply_length, link_event,
           device_state_out, ntb32_out, in_size_out,
    output ready
  );
endinterface

interface ncm_crh_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ncm_crh_pkg::CfgIdxW-1:0]   index;
  logic [31:0]                       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/ncm_crh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ncm_crh_cfg_regs
// configuration register file: interface number and max ntb input size
// ----------------------------------------------------------------------------
`default_nettype none

module ncm_crh_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [ncm_crh_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [31:0]                     wr_data_i,
  output      ncm_crh_pkg::cfg_t               cfg_o
);

  logic [7:0]  comm_idx_q;
  logic [31:0] in_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comm_idx_q <= 8'd0;
      in_max_q   <= ncm_crh_pkg::InMaxReset;
    end else if (wr_en_i) begin
      case (wr_index_i)
        ncm_crh_pkg::REG_COMM_IF_IDX: comm_idx_q <= wr_data_i[7:0];
        ncm_crh_pkg::REG_IN_MAX_SIZE: in_max_q   <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.comm_interface_index = comm_idx_q;
  assign cfg_o.ntb_in_max_size      = in_max_q;

endmodule

`default_nettype wire

// ----- src/ncm_crh_core.sv -----
// ----------------------------------------------------------------------------
// ncm_crh_core
// device and link state, and the decision logic for one bus event
// ----------------------------------------------------------------------------
`default_nettype none

module ncm_crh_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire ncm_crh_pkg::item_t  item_i,
  input  wire ncm_crh_pkg::cfg_t   cfg_i,
  output      ncm_crh_pkg::result_t res_o
);

  ncm_crh_pkg::dev_state_e dev_q, dev_d;
  logic [2:0]  speed_q, speed_d;
  logic [7:0]  alt_q, alt_d;
  logic        ntb32_q, ntb32_d;
  logic [31:0] size_q, size_d;
  logic        link_q, link_d;

  ncm_crh_pkg::action_e     action;
  ncm_crh_pkg::link_event_e lev;
  logic [31:0] rval;
  logic [4:0]  rlen;
  logic        take_down;
  logic        if_match;

  assign if_match = (item_i.setup_index == {8'd0, cfg_i.comm_interface_index});

  always_comb begin
    dev_d     = dev_q;
    speed_d   = speed_q;
    alt_d     = alt_q;
    ntb32_d   = ntb32_q;
    size_d    = size_q;
    link_d    = link_q;
    action    = ncm_crh_pkg::ACT_NONE;
    lev       = ncm_crh_pkg::LINK_NONE;
    rval      = 32'd0;
    rlen      = 5'd0;
    take_down = 1'b0;

    case (ncm_crh_pkg::func_e'(item_i.func))
      ncm_crh_pkg::EV_ATTACH: begin
        speed_d = item_i.bus_speed;
        dev_d   = ncm_crh_pkg::ST_ATTACHED;
      end
      ncm_crh_pkg::EV_CONFIGURED: dev_d = ncm_crh_pkg::ST_CONFIGURED;
      ncm_crh_pkg::EV_UNCONFIGURED: begin
        dev_d     = ncm_crh_pkg::ST_ATTACHED;
        take_down = 1'b1;
      end
      ncm_crh_pkg::EV_DETACH: begin
        dev_d     = ncm_crh_pkg::ST_DETACHED;
        take_down = 1'b1;
      end
      ncm_crh_pkg::EV_RESET: begin
        dev_d     = ncm_crh_pkg::ST_DEFAULT;
        speed_d   = item_i.bus_speed;
        take_down = 1'b1;
      end
      ncm_crh_pkg::EV_SETUP: begin
        action = ncm_crh_pkg::ACT_STALL;
        if (dev_q == ncm_crh_pkg::ST_CONFIGURED && if_match) begin
          case (ncm_crh_pkg::request_e'(item_i.request_code))
            ncm_crh_pkg::RQ_GET_PARAMS: begin
              if (item_i.setup_value == 16'd0 &&
                  item_i.setup_length >= ncm_crh_pkg::ParamBlockLen) begin
                action = ncm_crh_pkg::ACT_BLOCK;
                rlen   = ncm_crh_pkg::ParamBlockLen[4:0];
              end
            end
            ncm_crh_pkg::RQ_GET_FMT: begin
              if (item_i.setup_value == 16'd0 &&
                  item_i.setup_length >= ncm_crh_pkg::FmtReplyLen) begin
                action = ncm_crh_pkg::ACT_VALUE;
                rval   = {31'd0, ntb32_q};
                rlen   = ncm_crh_pkg::FmtReplyLen[4:0];
              end
            end
            ncm_crh_pkg::RQ_SET_FMT: begin
              if (item_i.setup_value[15:1] == 15'd0 && item_i.setup_length == 16'd0 &&
                  alt_q == 8'd0) begin
                ntb32_d = item_i.setup_value[0];
                action  = ncm_crh_pkg::ACT_HANDSHAKE;
              end
            end
            ncm_crh_pkg::RQ_GET_INSIZE: begin
              if (item_i.setup_value == 16'd0 &&
                  item_i.setup_length >= ncm_crh_pkg::SizeReplyLen) begin
                action = ncm_crh_pkg::ACT_VALUE;
                rval   = size_q;
                rlen   = ncm_crh_pkg::SizeReplyLen[4:0];
              end
            end
            ncm_crh_pkg::RQ_SET_INSIZE: begin
              if (item_i.setup_value == 16'd0 &&
                  item_i.setup_length == ncm_crh_pkg::SizeReplyLen) begin
                if (item_i.host_data >= ncm_crh_pkg::MinInSize &&
                    item_i.host_data <= cfg_i.ntb_in_max_size) begin
                  size_d = item_i.host_data;
                  if (link_q) lev = ncm_crh_pkg::LINK_RESTART;
                end
                action = ncm_crh_pkg::ACT_HANDSHAKE;
              end
            end
            default: ;
          endcase
        end
      end
      ncm_crh_pkg::EV_SET_IF: begin
        if (dev_q == ncm_crh_pkg::ST_CONFIGURED && item_i.alt_setting != alt_q) begin
          alt_d = item_i.alt_setting;
          if (item_i.alt_setting == 8'd0) begin
            take_down = 1'b1;
          end else if (item_i.alt_setting == 8'd1 && !link_q) begin
            link_d = 1'b1;
            lev    = ncm_crh_pkg::LINK_UP;
          end
        end
      end
      default: ;
    endcase

    // active link goes down: back to defaults
    if (take_down && link_q) begin
      link_d  = 1'b0;
      ntb32_d = 1'b0;
      size_d  = cfg_i.ntb_in_max_size;
      alt_d   = 8'd0;
      lev     = ncm_crh_pkg::LINK_DOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= ncm_crh_pkg::ST_DETACHED;
      speed_q <= 3'd0;
      alt_q   <= 8'd0;
      ntb32_q <= 1'b0;
      size_q  <= ncm_crh_pkg::InMaxReset;
      link_q  <= 1'b0;
    end else if (step_i) begin
      dev_q   <= dev_d;
      speed_q <= speed_d;
      alt_q   <= alt_d;
      ntb32_q <= ntb32_d;
      size_q  <= size_d;
      link_q  <= link_d;
    end
  end

  assign res_o.action           = action;
  assign res_o.reply_value      = rval;
  assign res_o.reply_length     = rlen;
  assign res_o.link_event       = lev;
  assign res_o.device_state_out = dev_d;
  assign res_o.ntb32_out        = ntb32_d;
  assign res_o.in_size_out      = size_d;

endmodule

`default_nettype wire

// ----- src/ncm_control_request_handler.sv -----
// ----------------------------------------------------------------------------
// ncm_control_request_handler
// usb cdc-ncm class request handler with device and link state tracking
//
// evt_i takes one bus event per word (attach, suspend, configured,
// unconfigured, detach, reset, setup, set interface). res_o returns exactly
// one result word per event: the endpoint zero action, reply value and
// length, link event, and the device state, ntb format and input size after
// the event. cfg_i writes the interface number (index 0) and the max ntb
// input size (index 1); it is always ready.
// an event is held in an input register and decided once the result
// register can advance: the state registers update and the result is
// registered. one event per cycle is taken while results keep flowing;
// the rate is set by the single decision stage.
// when res_o stalls, the result and input registers fill and evt_i.ready
// drops until the receiver takes the pending result.
// reset clears the state to detached, 16-bit ntb format, link inactive,
// input size 65536 and both registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ncm_control_request_handler (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ncm_crh_evt_if.sink evt_i,
  ncm_crh_res_if.source res_o,
  ncm_crh_cfg_if.sink cfg_i
);

  ncm_crh_pkg::cfg_t    cfg;
  ncm_crh_pkg::item_t   item_q;
  ncm_crh_pkg::result_t res_d, res_q;
  logic in_valid_q;
  logic out_valid_q;
  logic out_adv;
  logic step;

  assign cfg_i.ready = 1'b1;

  ncm_crh_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  assign out_adv     = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && out_adv;
  assign evt_i.ready = !in_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      item_q.func         <= evt_i.func;
      item_q.bus_speed    <= evt_i.bus_speed;
      item_q.request_code <= evt_i.request_code;
      item_q.setup_value  <= evt_i.setup_value;
      item_q.setup_index  <= evt_i.setup_index;
      item_q.setup_length <= evt_i.setup_length;
      item_q.host_data    <= evt_i.host_data;
      item_q.alt_setting  <= evt_i.alt_setting;
    end
  end

  ncm_crh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.action           = res_q.action;
  assign res_o.reply_value      = res_q.reply_value;
  assign res_o.reply_length     = res_q.reply_length;
  assign res_o.link_event       = res_q.link_event;
  assign res_o.device_state_out = res_q.device_state_out;
  assign res_o.ntb32_out        = res_q.ntb32_out;
  assign res_o.in_size_out      = res_q.in_size_out;

endmodule

`default_nettype wire

// ----- tb/ncm_control_request_handler_tb.sv -----
// ----------------------------------------------------------------------------
// ncm_control_request_handler_tb
// self-checking bench for the cdc-ncm class request handler
//
// sends bus events through a short directed table, then random event mixes
// across several register settings and idle patterns. every accepted event
// is run through a local predictor of the handler, and every result word is
// compared field by field with the oldest expected response.
// ----------------------------------------------------------------------------
`default_nettype none

module ncm_control_request_handler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncm_crh_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int PhaseEvents = 370;

  typedef struct packed {
    logic    pinned;
    result_t r;
  } pinned_t;

  typedef struct {
    item_t   it;
    bit      pinned;
    result_t r;
  } row_t;

  logic clk_i;
  logic rst_ni;

  ncm_crh_evt_if evt_bus ();
  ncm_crh_res_if res_bus ();
  ncm_crh_cfg_if cfg_bus ();

  ncm_control_request_handler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // predictor state
  logic [7:0]  m_if_idx;
  logic [31:0] m_in_max;
  dev_state_e  m_state;
  logic [2:0]  m_speed;
  logic [7:0]  m_alt;
  logic        m_ntb32;
  logic [31:0] m_in_size;
  logic        m_link;

  result_t predicted_responses[$];
  pinned_t pinned_q[$];
  row_t    dir_rows[$];

  int mismatches;
  int events_taken;
  int n_stall, n_block, n_value, n_shake, n_link;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_req;
  int          hold_seen;
  int          hold_left;
  logic [7:0]  ph_if;
  logic [31:0] ph_max;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("ncm_control_request_handler_tb failed");
    $finish;
  end

  function automatic link_event_e drop_link();
    if (!m_link) return LINK_NONE;
    m_link    = 1'b0;
    m_ntb32   = 1'b0;
    m_in_size = m_in_max;
    m_alt     = 8'd0;
    return LINK_DOWN;
  endfunction

  function automatic result_t handle_event(input item_t it);
    result_t r;
    r = '0;
    r.action = ACT_NONE;
    r.link_event = LINK_NONE;
    case (func_e'(it.func))
      EV_ATTACH: begin
        m_speed = it.bus_speed;
        m_state = ST_ATTACHED;
      end
      EV_CONFIGURED: m_state = ST_CONFIGURED;
      EV_UNCONFIGURED: begin
        m_state = ST_ATTACHED;
        r.link_event = drop_link();
      end
      EV_DETACH: begin
        m_state = ST_DETACHED;
        r.link_event = drop_link();
      end
      EV_RESET: begin
        m_state = ST_DEFAULT;
        m_speed = it.bus_speed;
        r.link_event = drop_link();
      end
      EV_SETUP: begin
        r.action = ACT_STALL;
        if (m_state == ST_CONFIGURED && it.setup_index == {8'd0, m_if_idx}) begin
          case (it.request_code)
            RQ_GET_PARAMS: if (it.setup_value == 16'd0 && it.setup_length >= ParamBlockLen) begin
              r.action = ACT_BLOCK;
              r.reply_length = ParamBlockLen[4:0];
            end
            RQ_GET_FMT: if (it.setup_value == 16'd0 && it.setup_length >= FmtReplyLen) begin
              r.action = ACT_VALUE;
              r.reply_value = {31'd0, m_ntb32};
              r.reply_length = FmtReplyLen[4:0];
            end
            RQ_SET_FMT: begin
              if (it.setup_value <= 16'd1 && it.setup_length == 16'd0 && m_alt == 8'd0) begin
                m_ntb32 = it.setup_value[0];
                r.action = ACT_HANDSHAKE;
              end
            end
            RQ_GET_INSIZE: if (it.setup_value == 16'd0 && it.setup_length >= SizeReplyLen) begin
              r.action = ACT_VALUE;
              r.reply_value = m_in_size;
              r.reply_length = SizeReplyLen[4:0];
            end
            RQ_SET_INSIZE: if (it.setup_value == 16'd0 && it.setup_length == SizeReplyLen) begin
              if (it.host_data >= MinInSize && it.host_data <= m_in_max) begin
                m_in_size = it.host_data;
                if (m_link) r.link_event = LINK_RESTART;
              end
              r.action = ACT_HANDSHAKE;
            end
            default: ;
          endcase
        end
      end
      EV_SET_IF: begin
        if (m_state == ST_CONFIGURED && it.alt_setting != m_alt) begin
          m_alt = it.alt_setting;
          if (it.alt_setting == 8'd0) begin
            r.link_event = drop_link();
          end else if (it.alt_setting == 8'd1 && !m_link) begin
            m_link = 1'b1;
            r.link_event = LINK_UP;
          end
        end
      end
      default: ;
    endcase
    r.device_state_out = m_state;
    r.ntb32_out = m_ntb32;
    r.in_size_out = m_in_size;
    return r;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("act=%0d val=%h len=%0d link=%0d st=%0d n32=%0d size=%h",
                     r.action, r.reply_value, r.reply_length, r.link_event,
                     r.device_state_out, r.ntb32_out, r.in_size_out);
  endfunction

  task automatic report(input string what, input result_t e, input result_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d: %s", mismatches, what);
      $display("  expected %s", fmt_result(e));
      $display("  actual   %s", fmt_result(g));
    end
  endtask

  task automatic compare_response(input result_t e, input result_t g);
    string diff;
    diff = "";
    if (g.action !== e.action) diff = {diff, " action"};
    if (g.reply_value !== e.reply_value) diff = {diff, " reply_value"};
    if (g.reply_length !== e.reply_length) diff = {diff, " reply_length"};
    if (g.link_event !== e.link_event) diff = {diff, " link_event"};
    if (g.device_state_out !== e.device_state_out) diff = {diff, " device_state_out"};
    if (g.ntb32_out !== e.ntb32_out) diff = {diff, " ntb32_out"};
    if (g.in_size_out !== e.in_size_out) diff = {diff, " in_size_out"};
    if (diff != "") report({"wrong field:", diff}, e, g);
  endtask

  always @(posedge clk_i) begin : watch
    item_t   seen;
    result_t got;
    result_t want;
    pinned_t p;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_COMM_IF_IDX: m_if_idx = cfg_bus.data[7:0];
          REG_IN_MAX_SIZE: m_in_max = cfg_bus.data;
          default: ;
        endcase
      end
      if (evt_bus.valid && evt_bus.ready) begin
        seen = {evt_bus.func, evt_bus.bus_speed, evt_bus.request_code, evt_bus.setup_value,
                evt_bus.setup_index, evt_bus.setup_length, evt_bus.host_data,
                evt_bus.alt_setting};
        p = pinned_q.pop_front();
        want = handle_event(seen);
        predicted_responses.push_back(p.pinned ? p.r : want);
        events_taken++;
      end
      if (res_bus.valid && res_bus.ready) begin
        got = {res_bus.action, res_bus.reply_value, res_bus.reply_length, res_bus.link_event,
               res_bus.device_state_out, res_bus.ntb32_out, res_bus.in_size_out};
        if (predicted_responses.size() == 0) begin
          report("result word with nothing expected", '0, got);
        end else begin
          want = predicted_responses.pop_front();
          compare_response(want, got);
          case (action_e'(want.action))
            ACT_STALL:     n_stall++;
            ACT_BLOCK:     n_block++;
            ACT_VALUE:     n_value++;
            ACT_HANDSHAKE: n_shake++;
            default: ;
          endcase
          if (want.link_event != LINK_NONE) n_link++;
        end
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic item_t ev(input func_e f, input logic [2:0] sp, input logic [7:0] rq,
                               input logic [15:0] v, input logic [15:0] i,
                               input logic [15:0] l, input logic [31:0] d,
                               input logic [7:0] a);
    return {f, sp, rq, v, i, l, d, a};
  endfunction

  function automatic result_t rs(input action_e a, input logic [31:0] v, input logic [4:0] l,
                                 input link_event_e k, input dev_state_e s, input logic n,
                                 input logic [31:0] z);
    return {a, v, l, k, s, n, z};
  endfunction

  task automatic add_row(input item_t it, input bit pinned, input result_t r);
    row_t row;
    row.it = it;
    row.pinned = pinned;
    row.r = r;
    dir_rows.push_back(row);
  endtask

  task automatic build_table();
    add_row(ev(EV_SETUP, 3'd0, RQ_GET_PARAMS, 16'd0, 16'd0, 16'd28, 32'd0, 8'd0), 1,
            rs(ACT_STALL, 32'd0, 5'd0, LINK_NONE, ST_DETACHED, 1'b0, InMaxReset));
    add_row(ev(EV_ATTACH, 3'd7, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_NONE, 32'd0, 5'd0, LINK_NONE, ST_ATTACHED, 1'b0, InMaxReset));
    add_row(ev(EV_SUSPEND, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_NONE, 32'd0, 5'd0, LINK_NONE, ST_ATTACHED, 1'b0, InMaxReset));
    add_row(ev(EV_RESET, 3'd5, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_NONE, 32'd0, 5'd0, LINK_NONE, ST_DEFAULT, 1'b0, InMaxReset));
    add_row(ev(EV_SET_IF, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd1), 1,
            rs(ACT_NONE, 32'd0, 5'd0, LINK_NONE, ST_DEFAULT, 1'b0, InMaxReset));
    add_row(ev(EV_CONFIGURED, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_NONE, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b0, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_GET_PARAMS, 16'd0, 16'd0, 16'd28, 32'd0, 8'd0), 1,
            rs(ACT_BLOCK, 32'd0, 5'd28, LINK_NONE, ST_CONFIGURED, 1'b0, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_GET_PARAMS, 16'd0, 16'd0, 16'd27, 32'd0, 8'd0), 1,
            rs(ACT_STALL, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b0, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_GET_FMT, 16'd0, 16'd0, 16'd2, 32'd0, 8'd0), 1,
            rs(ACT_VALUE, 32'd0, 5'd2, LINK_NONE, ST_CONFIGURED, 1'b0, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_FMT, 16'd1, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_HANDSHAKE, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_FMT, 16'd2, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_STALL, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_GET_INSIZE, 16'd0, 16'd0, 16'hffff, 32'd0, 8'd0), 1,
            rs(ACT_VALUE, InMaxReset, 5'd4, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_INSIZE, 16'd0, 16'd0, 16'd4, 32'd2048, 8'd0), 1,
            rs(ACT_HANDSHAKE, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, 32'd2048));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_INSIZE, 16'd0, 16'd0, 16'd4, 32'd2047, 8'd0), 1,
            rs(ACT_HANDSHAKE, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, 32'd2048));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_INSIZE, 16'd0, 16'd0, 16'd4, 32'hffff_ffff, 8'd0), 1,
            rs(ACT_HANDSHAKE, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, 32'd2048));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_INSIZE, 16'd0, 16'd0, 16'd4, InMaxReset, 8'd0), 1,
            rs(ACT_HANDSHAKE, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_INSIZE, 16'd0, 16'd0, 16'd5, 32'd4096, 8'd0), 1,
            rs(ACT_STALL, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_GET_FMT, 16'd0, 16'hffff, 16'd2, 32'd0, 8'd0), 1,
            rs(ACT_STALL, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, 8'hff, 16'd0, 16'd0, 16'd4, 32'd0, 8'd0), 1,
            rs(ACT_STALL, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SET_IF, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd1), 1,
            rs(ACT_NONE, 32'd0, 5'd0, LINK_UP, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_FMT, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_STALL, 32'd0, 5'd0, LINK_NONE, ST_CONFIGURED, 1'b1, InMaxReset));
    add_row(ev(EV_SETUP, 3'd0, RQ_SET_INSIZE, 16'd0, 16'd0, 16'd4, 32'd4096, 8'd0), 1,
            rs(ACT_HANDSHAKE, 32'd0, 5'd0, LINK_RESTART, ST_CONFIGURED, 1'b1, 32'd4096));
    add_row(ev(EV_SET_IF, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'hff), 0, '0);
    add_row(ev(EV_SET_IF, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 1,
            rs(ACT_NONE, 32'd0, 5'd0, LINK_DOWN, ST_CONFIGURED, 1'b0, InMaxReset));
    add_row(ev(EV_SET_IF, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd1), 0, '0);
    add_row(ev(EV_UNCONFIGURED, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 0, '0);
    add_row(ev(EV_DETACH, 3'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 8'd0), 0, '0);
  endtask

  function automatic item_t gen_event();
    item_t    it;
    int       roll;
    request_e rq_tab[5] = '{RQ_GET_PARAMS, RQ_GET_FMT, RQ_SET_FMT, RQ_GET_INSIZE,
                            RQ_SET_INSIZE};
    it.func = 3'($urandom);
    it.bus_speed = 3'($urandom);
    it.request_code = 8'($urandom);
    it.setup_value = 16'($urandom);
    it.setup_index = 16'($urandom);
    it.setup_length = 16'($urandom);
    it.host_data = $urandom;
    it.alt_setting = 8'($urandom);
    if ($urandom_range(0, 9) == 0) return it;
    roll = $urandom_range(0, 99);
    if (roll < 50) it.func = EV_SETUP;
    else if (roll < 64) it.func = EV_SET_IF;
    else if (roll < 74) it.func = EV_CONFIGURED;
    else if (roll < 79) it.func = EV_ATTACH;
    else if (roll < 84) it.func = EV_SUSPEND;
    else if (roll < 89) it.func = EV_UNCONFIGURED;
    else if (roll < 94) it.func = EV_DETACH;
    else it.func = EV_RESET;
    if (it.func == EV_SETUP) begin
      if ($urandom_range(0, 9) != 0) it.setup_index = {8'd0, ph_if};
      if ($urandom_range(0, 9) != 0) it.request_code = rq_tab[$urandom_range(0, 4)];
      if ($urandom_range(0, 3) != 0) begin
        it.setup_value = (it.request_code == RQ_SET_FMT) ? 16'($urandom_range(0, 1)) : 16'd0;
        case (it.request_code)
          RQ_GET_PARAMS:
            it.setup_length = $urandom_range(0, 1) ? 16'd28 : 16'($urandom_range(28, 65535));
          RQ_GET_FMT:
            it.setup_length = $urandom_range(0, 1) ? 16'd2 : 16'($urandom_range(2, 65535));
          RQ_SET_FMT:    it.setup_length = 16'd0;
          RQ_GET_INSIZE:
            it.setup_length = $urandom_range(0, 1) ? 16'd4 : 16'($urandom_range(4, 65535));
          RQ_SET_INSIZE: it.setup_length = SizeReplyLen;
          default: ;
        endcase
      end else begin
        if ($urandom_range(0, 1)) it.setup_value = 16'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) it.setup_length = 16'($urandom_range(0, 5));
        else if ($urandom_range(0, 1)) it.setup_length = 16'd27;
      end
      case ($urandom_range(0, 6))
        0: it.host_data = MinInSize;
        1: it.host_data = ph_max;
        2: it.host_data = MinInSize - 32'd1;
        3: it.host_data = ph_max + 32'd1;
        4, 5: it.host_data = $urandom_range(ph_max, MinInSize);
        default: ;
      endcase
    end else if (it.func == EV_SET_IF) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) it.alt_setting = 8'd1;
      else if (roll < 7) it.alt_setting = 8'd0;
      else if (roll == 7) it.alt_setting = 8'($urandom_range(2, 3));
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit pinned, input result_t r);
    pinned_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      evt_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    p.pinned = pinned;
    p.r = r;
    pinned_q.push_back(p);
    evt_bus.valid        <= 1'b1;
    evt_bus.func         <= it.func;
    evt_bus.bus_speed    <= it.bus_speed;
    evt_bus.request_code <= it.request_code;
    evt_bus.setup_value  <= it.setup_value;
    evt_bus.setup_index  <= it.setup_index;
    evt_bus.setup_length <= it.setup_length;
    evt_bus.host_data    <= it.host_data;
    evt_bus.alt_setting  <= it.alt_setting;
    do @(posedge clk_i); while (!evt_bus.ready);
  endtask

  task automatic drain();
    evt_bus.valid <= 1'b0;
    do @(posedge clk_i); while (predicted_responses.size() != 0);
  endtask

  task automatic set_config(input logic [7:0] if_idx, input logic [31:0] in_max);
    ph_if = if_idx;
    ph_max = in_max;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_COMM_IF_IDX;
    cfg_bus.data  <= {24'd0, if_idx};
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.index <= REG_IN_MAX_SIZE;
    cfg_bus.data  <= in_max;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int hold_at;
    m_if_idx  = 8'd0;
    m_in_max  = InMaxReset;
    m_state   = ST_DETACHED;
    m_speed   = 3'd0;
    m_alt     = 8'd0;
    m_ntb32   = 1'b0;
    m_in_size = InMaxReset;
    m_link    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req  = 0;
    hold_seen = 0;
    hold_left = 0;
    rst_ni <= 1'b0;
    evt_bus.valid <= 1'b0;
    evt_bus.func <= '0;
    evt_bus.bus_speed <= '0;
    evt_bus.request_code <= '0;
    evt_bus.setup_value <= '0;
    evt_bus.setup_index <= '0;
    evt_bus.setup_length <= '0;
    evt_bus.host_data <= '0;
    evt_bus.alt_setting <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    build_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(8'd0, InMaxReset);
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].pinned, dir_rows[k].r);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      hold_at = -1;
      case (ph)
        0: begin set_config(8'd0, InMaxReset); send_idle_pct = 0; recv_stall_pct = 0;
                 hold_at = 120; end
        1: begin set_config(8'd255, MinInSize); send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin set_config(8'd90, 32'hffff_ffff); send_idle_pct = 0; recv_stall_pct = 67; end
        3: begin set_config(8'($urandom_range(0, 255)), $urandom_range(32'hffff_ffff, 2048));
                 send_idle_pct = 31; recv_stall_pct = 31; hold_at = 200; end
        default: begin set_config(8'd1, 32'h4000); send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < PhaseEvents; n++) begin
        if (n == hold_at) hold_req <= hold_req + 1;
        send_item(gen_event(), 1'b0, '0);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (predicted_responses.size() != 0) begin
      mismatches++;
      $display("%0d expected result words never arrived", predicted_responses.size());
    end
    $display("%0d bus events over 6 register settings and 4 idle patterns", events_taken);
    $display("stalls %0d, parameter blocks %0d, replies %0d, handshakes %0d, link events %0d",
             n_stall, n_block, n_value, n_shake, n_link);
    if (mismatches == 0) begin
      $display("ncm_control_request_handler_tb passed");
    end else begin
      $display("ncm_control_request_handler_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/ncm_crh_pkg.sv
src/ncm_crh_if.sv
src/ncm_crh_cfg_regs.sv
src/ncm_crh_core.sv
src/ncm_control_request_handler.sv
tb/ncm_control_request_handler_tb.sv
